// ----- rtl/vrsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrsd_pkg
// Shared types, constants and helpers of the route split decoder.
// ----------------------------------------------------------------------------
package vrsd_pkg;

  localparam int          MAX_CUSTOMERS_DEF = 256;
  localparam logic [9:0]  CAP_RESET         = 10'd200;
  localparam logic [31:0] SAT32             = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]  customer_id;
    logic [9:0]  demand;
    logic [23:0] ready_time;
    logic [23:0] due_time;
    logic [23:0] service_time;
    logic [23:0] dist_from_prev;
    logic [23:0] dist_from_depot;
    logic        last_customer;
  } vrsd_in_t;

  typedef struct packed {
    logic [7:0]  assigned_customer;
    logic [7:0]  route_index;
    logic        starts_route;
    logic [31:0] total_distance;
    logic [8:0]  route_count;
    logic        done_res;
  } vrsd_out_t;

  // saturate a wide unsigned sum to 32 bits
  function automatic logic [31:0] sat32(input logic [34:0] v);
    return (|v[34:32]) ? SAT32 : v[31:0];
  endfunction

endpackage

// ----- rtl/vrsd_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrsd_in_stage
// Input register holding one customer transaction until it is decoded.
// ----------------------------------------------------------------------------
module vrsd_in_stage import vrsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  vrsd_in_t in_data,
  input  logic     adv,
  output logic     item_valid,
  output vrsd_in_t item
);

  logic     vld_r, vld_nxt;
  vrsd_in_t data_r;
  logic     take;

  assign in_ready = !vld_r || adv;
  assign take     = in_valid && in_ready;
  assign vld_nxt  = take || (vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data;
    end
  end

  assign item_valid = vld_r;
  assign item       = data_r;

endmodule

// ----- rtl/vrsd_route_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrsd_route_state
// Route state registers and the greedy split decision for one customer.
// ----------------------------------------------------------------------------
module vrsd_route_state import vrsd_pkg::*; #(
  parameter int MAX_CUSTOMERS = MAX_CUSTOMERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  vrsd_in_t   item,
  input  logic [9:0] capacity,
  output vrsd_out_t  res
);

  localparam int             RW        = $clog2(MAX_CUSTOMERS);
  localparam logic [RW-1:0]  ROUTE_MAX = RW'(MAX_CUSTOMERS - 1);

  logic [31:0]   clock_r, clock_nxt;
  logic [10:0]   load_r, load_nxt;
  logic [31:0]   rdist_r, rdist_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic [RW-1:0] route_r, route_nxt;
  logic          start_r;
  logic [23:0]   pdep_r;

  logic [31:0] try_arr, arrival, svc_start, rdist_join, sum_split;
  logic [31:0] total_split, total_join, total_start, total;
  logic [11:0] try_load;
  logic        split, opens;

  always_comb begin
    try_arr   = sat32({3'b0, clock_r} + {11'b0, item.dist_from_prev});
    try_load  = {1'b0, load_r} + {2'b0, item.demand};
    split     = !start_r && ((try_arr > {8'b0, item.due_time}) ||
                             (try_load > {2'b0, capacity}));
    opens     = start_r || split;
    arrival   = opens ? {8'b0, item.dist_from_depot} : try_arr;
    svc_start = (arrival > {8'b0, item.ready_time}) ? arrival : {8'b0, item.ready_time};
    clock_nxt = sat32({3'b0, svc_start} + {11'b0, item.service_time});
    load_nxt  = opens ? {1'b0, item.demand} : try_load[10:0];

    rdist_join = sat32({3'b0, rdist_r} + {11'b0, item.dist_from_prev});
    rdist_nxt  = opens ? {8'b0, item.dist_from_depot} : rdist_join;
    sum_split  = sat32({3'b0, sum_r} + {3'b0, rdist_r} + {11'b0, pdep_r});
    sum_nxt    = split ? sum_split : sum_r;

    if (split && (route_r < ROUTE_MAX)) begin
      route_nxt = route_r + RW'(1);
    end else begin
      route_nxt = route_r;
    end

    // closing leg to the depot folded into one saturating sum for the split and join cases
    total_split = sat32({3'b0, sum_r} + {3'b0, rdist_r} + {11'b0, pdep_r} +
                        {11'b0, item.dist_from_depot} + {11'b0, item.dist_from_depot});
    total_join  = sat32({3'b0, sum_r} + {3'b0, rdist_r} +
                        {11'b0, item.dist_from_prev} + {11'b0, item.dist_from_depot});
    total_start = {7'b0, item.dist_from_depot, 1'b0};

    priority if (split) begin
      total = total_split;
    end else if (start_r) begin
      total = total_start;
    end else begin
      total = total_join;
    end

    res.assigned_customer = item.customer_id;
    res.route_index       = 8'(route_nxt);
    res.starts_route      = opens;
    res.total_distance    = item.last_customer ? total : 32'd0;
    res.route_count       = item.last_customer ? (9'(route_nxt) + 9'd1) : 9'd0;
    res.done_res          = item.last_customer;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
      load_r  <= '0;
      rdist_r <= '0;
      sum_r   <= '0;
      route_r <= '0;
      start_r <= 1'b1;
      pdep_r  <= '0;
    end else if (adv) begin
      if (item.last_customer) begin
        clock_r <= '0;
        load_r  <= '0;
        rdist_r <= '0;
        sum_r   <= '0;
        route_r <= '0;
        start_r <= 1'b1;
        pdep_r  <= '0;
      end else begin
        clock_r <= clock_nxt;
        load_r  <= load_nxt;
        rdist_r <= rdist_nxt;
        sum_r   <= sum_nxt;
        route_r <= route_nxt;
        start_r <= 1'b0;
        pdep_r  <= item.dist_from_depot;
      end
    end
  end

endmodule

// ----- rtl/vrsd_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrsd_out_stage
// Result register; decides when the decoded transaction moves forward.
// ----------------------------------------------------------------------------
module vrsd_out_stage import vrsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  vrsd_out_t res,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_ready,
  output vrsd_out_t out_data
);

  logic      vld_r, vld_nxt;
  vrsd_out_t data_r;

  assign adv     = item_valid && (!vld_r || out_ready);
  assign vld_nxt = adv || (vld_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

// ----- rtl/vrsd_route_split_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrptw_route_split_decoder_core
// Pipeline: a transaction is held in the input register, decoded by the
// combinational split decision and held in the result register until taken.
// Throughput: one customer per cycle while the result side is not stalling.
// Reset (rst_n low, synchronous): route state cleared, capacity back to 200,
// both channels empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module vrptw_route_split_decoder_core import vrsd_pkg::*; #(
  parameter int MAX_CUSTOMERS = MAX_CUSTOMERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  vrsd_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output vrsd_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [9:0] cfg_data
);

  logic       cap_we;
  logic [9:0] capacity_r;
  logic       adv, item_valid;
  vrsd_in_t   item;
  vrsd_out_t  res;

  assign cfg_ready = 1'b1;
  assign cap_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cap_we) begin
      capacity_r <= cfg_data;
    end
  end

  vrsd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  vrsd_route_state #(
    .MAX_CUSTOMERS (MAX_CUSTOMERS)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .item     (item),
    .capacity (capacity_r),
    .res      (res)
  );

  vrsd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .res        (res),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the route split decoder. Customers are streamed in
// with random gaps while the result side stalls at random. Each accepted
// customer is run through a local model of the greedy split (time windows,
// capacity, route saturation, saturating distance sums) and every result is
// compared field by field against the oldest predicted placement.
// ----------------------------------------------------------------------------
module tb;
  import vrsd_pkg::*;

  localparam int MAX_ROUTES = MAX_CUSTOMERS_DEF;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  vrsd_in_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  vrsd_out_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [9:0] cfg_data = '0;

  vrptw_route_split_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // model state
  logic [9:0]  capacity_shadow;
  logic [31:0] route_clock_m;
  logic [10:0] route_load_m;
  logic [31:0] route_dist_m;
  logic [31:0] closed_sum_m;
  logic [8:0]  route_m;
  logic        chrom_start_m;
  logic [23:0] prev_depot_m;

  vrsd_out_t placement_q[$];
  int        error_count = 0;
  bit        gaps_on = 1'b1;
  bit        stalls_on = 1'b1;
  int        stall_left = 0;

  function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void clear_routes();
    route_clock_m = '0;
    route_load_m  = '0;
    route_dist_m  = '0;
    closed_sum_m  = '0;
    route_m       = '0;
    chrom_start_m = 1'b1;
    prev_depot_m  = '0;
  endfunction

  function automatic vrsd_out_t predict_placement(input vrsd_in_t c);
    vrsd_out_t   r;
    logic        opens;
    logic [31:0] arrival;
    logic [31:0] try_arr;
    logic [31:0] closing;
    logic [10:0] try_load;
    r = '0;
    if (chrom_start_m) begin
      opens   = 1'b1;
      arrival = {8'd0, c.dist_from_depot};
    end else begin
      try_arr  = add_sat(route_clock_m, {8'd0, c.dist_from_prev});
      try_load = route_load_m + {1'b0, c.demand};
      if (try_arr > {8'd0, c.due_time} || try_load > {1'b0, capacity_shadow}) begin
        route_dist_m = add_sat(route_dist_m, {8'd0, prev_depot_m});
        closed_sum_m = add_sat(closed_sum_m, route_dist_m);
        if (route_m < 9'(MAX_ROUTES - 1)) route_m = route_m + 9'd1;
        opens   = 1'b1;
        arrival = {8'd0, c.dist_from_depot};
      end else begin
        opens   = 1'b0;
        arrival = try_arr;
      end
    end
    if (opens) begin
      route_load_m = {1'b0, c.demand};
      route_dist_m = {8'd0, c.dist_from_depot};
    end else begin
      route_load_m = route_load_m + {1'b0, c.demand};
      route_dist_m = add_sat(route_dist_m, {8'd0, c.dist_from_prev});
    end
    route_clock_m = add_sat((arrival > {8'd0, c.ready_time}) ? arrival : {8'd0, c.ready_time},
                            {8'd0, c.service_time});
    prev_depot_m  = c.dist_from_depot;
    chrom_start_m = 1'b0;
    r.assigned_customer = c.customer_id;
    r.route_index       = route_m[7:0];
    r.starts_route      = opens;
    r.done_res          = c.last_customer;
    if (c.last_customer) begin
      closing          = add_sat(route_dist_m, {8'd0, c.dist_from_depot});
      r.total_distance = add_sat(closed_sum_m, closing);
      r.route_count    = route_m + 9'd1;
      clear_routes();
    end
    return r;
  endfunction

  function automatic vrsd_in_t customer(input logic [7:0] id, input logic [9:0] dem,
                                        input logic [23:0] rdy, input logic [23:0] due,
                                        input logic [23:0] serv, input logic [23:0] dprev,
                                        input logic [23:0] ddep, input logic fin);
    vrsd_in_t c;
    c.customer_id     = id;
    c.demand          = dem;
    c.ready_time      = rdy;
    c.due_time        = due;
    c.service_time    = serv;
    c.dist_from_prev  = dprev;
    c.dist_from_depot = ddep;
    c.last_customer   = fin;
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      out_ready  <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
                                                  $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    vrsd_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (placement_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: cust %0d route %0d", out_data.assigned_customer,
                   out_data.route_index);
      end else begin
        want = placement_q.pop_front();
        if (out_data !== want) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch exp: cust %0d route %0d start %0b dist %h count %0d done %0b",
                     want.assigned_customer, want.route_index, want.starts_route,
                     want.total_distance, want.route_count, want.done_res);
            $display("         got: cust %0d route %0d start %0b dist %h count %0d done %0b",
                     out_data.assigned_customer, out_data.route_index, out_data.starts_route,
                     out_data.total_distance, out_data.route_count, out_data.done_res);
          end
        end
      end
    end
  end

  task automatic send_customer(input vrsd_in_t c);
    int        gap;
    vrsd_out_t pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    pred        = predict_placement(c);
    placement_q = {placement_q, pred};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [9:0] cap);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity_shadow = cap;
  endtask

  // reset capacity of 200: third customer pushes load to 201
  task automatic test_default_capacity();
    send_customer(customer(8'd1, 10'd100, 24'h0, 24'hFFFFFF, 24'h10, 24'h0, 24'h20, 1'b0));
    send_customer(customer(8'd2, 10'd100, 24'h0, 24'hFFFFFF, 24'h10, 24'h8, 24'h30, 1'b0));
    send_customer(customer(8'd3, 10'd1, 24'h0, 24'hFFFFFF, 24'h10, 24'h8, 24'h40, 1'b0));
    send_customer(customer(8'd4, 10'd0, 24'h0, 24'hFFFFFF, 24'h10, 24'h8, 24'h50, 1'b1));
  endtask

  // first customer waits for ready, arrival equal to due joins, late splits
  task automatic test_time_window();
    send_customer(customer(8'd10, 10'd5, 24'h200, 24'h0, 24'h50, 24'h0, 24'h100, 1'b0));
    send_customer(customer(8'd11, 10'd5, 24'h0, 24'h260, 24'h20, 24'h10, 24'h110, 1'b0));
    send_customer(customer(8'd12, 10'd5, 24'h0, 24'h10, 24'h20, 24'h10, 24'h120, 1'b0));
    send_customer(customer(8'd13, 10'd5, 24'h300, 24'hFFFFFF, 24'h20, 24'h30, 24'h130, 1'b1));
  endtask

  // single customer chromosomes at the field extremes, oversized first customer
  task automatic test_field_extremes();
    send_customer('0 | vrsd_in_t'(1));
    send_customer('1);
    send_customer(customer(8'd20, 10'h3FF, 24'h0, 24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    send_customer(customer(8'd21, 10'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                           24'h0, 1'b0));
    send_customer(customer(8'd22, 10'd0, 24'h0, 24'hFFFFFF, 24'h0, 24'h0, 24'h1, 1'b1));
  endtask

  // zero and full capacity
  task automatic test_capacity_limits();
    write_capacity(10'd0);
    send_customer(customer(8'd30, 10'd0, 24'h0, 24'hFFFFFF, 24'h1, 24'h0, 24'h4, 1'b0));
    send_customer(customer(8'd31, 10'd0, 24'h0, 24'hFFFFFF, 24'h1, 24'h2, 24'h4, 1'b0));
    send_customer(customer(8'd32, 10'd1, 24'h0, 24'hFFFFFF, 24'h1, 24'h2, 24'h4, 1'b1));
    write_capacity(10'h3FF);
    send_customer(customer(8'd33, 10'h3FF, 24'h0, 24'hFFFFFF, 24'h1, 24'h0, 24'h8, 1'b0));
    send_customer(customer(8'd34, 10'd0, 24'h0, 24'hFFFFFF, 24'h1, 24'h2, 24'h8, 1'b0));
    send_customer(customer(8'd35, 10'd1, 24'h0, 24'hFFFFFF, 24'h1, 24'h2, 24'h8, 1'b1));
  endtask

  // every customer after the first splits: route index saturates and the distance sum clips
  task automatic test_route_overflow();
    int i;
    write_capacity(10'd0);
    for (i = 0; i < 260; i++)
      send_customer(customer(8'(i), 10'd1, 24'h0, 24'hFFFFFF, 24'h0, 24'h0, 24'hFFFFFF,
                             i == 259));
  endtask

  task automatic test_random_chromosomes();
    int           phase;
    int           k;
    int           n_left;
    int           t_est;
    int           est;
    int           rdy;
    logic [159:0] raw;
    vrsd_in_t     c;
    n_left = 0;
    t_est  = 0;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       write_capacity(10'd0);
        1:       write_capacity(10'h3FF);
        2:       write_capacity(10'd200);
        3:       write_capacity(10'd1);
        default: write_capacity(10'($urandom_range(0, 1023)));
      endcase
      gaps_on   = (phase % 3) != 2;
      stalls_on = (phase % 4) != 3;
      for (k = 0; k < 65; k++) begin
        if (n_left == 0) begin
          n_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          t_est  = 0;
        end
        if ($urandom_range(0, 7) == 0) begin
          raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
          c   = raw[$bits(vrsd_in_t)-1:0];
          if (c.last_customer) n_left = 0;
        end else begin
          c.customer_id     = 8'($urandom);
          c.demand          = 10'($urandom_range(0, capacity_shadow / 3 + 2));
          c.dist_from_prev  = 24'($urandom_range(0, 'h400));
          c.dist_from_depot = 24'($urandom_range(0, 'h800));
          c.service_time    = 24'($urandom_range(0, 'h200));
          est = t_est + int'(c.dist_from_prev);
          rdy = est + $urandom_range(0, 'h200) - 'h100;
          c.ready_time = 24'((rdy < 0) ? 0 : rdy);
          c.due_time   = ($urandom_range(0, 5) == 0) ? 24'($urandom_range(0, est)) :
                                                        24'(est + $urandom_range(0, 'h600));
          c.last_customer = (n_left == 1);
          t_est  = ((est > rdy) ? est : rdy) + int'(c.service_time);
          n_left = n_left - 1;
        end
        send_customer(c);
      end
    end
  endtask

  initial begin
    capacity_shadow = CAP_RESET;
    clear_routes();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_capacity();
    test_time_window();
    test_field_extremes();
    test_capacity_limits();
    test_route_overflow();
    test_random_chromosomes();
    drain_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
